@@ rtl/apec_pkg.sv @@
// Shared types and constants for the anisotropy encoding converter.
// No dependencies.
`default_nettype none

package apec_pkg;

    localparam int NUM_CELLS    = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int SQRT_STEPS   = 10;
    localparam int DIR_SHIFT    = 12;

    // input formats
    localparam logic [1:0] IFMT_SIGNED = 2'd0;
    localparam logic [1:0] IFMT_3CH    = 2'd1;
    localparam logic [1:0] IFMT_2D     = 2'd2;
    // output formats
    localparam logic [1:0] OFMT_3CH    = 2'd0;
    localparam logic [1:0] OFMT_2D     = 2'd1;
    localparam logic [1:0] OFMT_ANGLE  = 2'd2;
    // register indexes
    localparam logic REG_IN_FMT  = 1'b0;
    localparam logic REG_OUT_FMT = 1'b1;

    typedef enum logic [2:0] {
        MODE_PASS,   // 3ch -> 3ch
        MODE_DIR_S,  // 3ch -> 2D, scale by strength
        MODE_DIR_M,  // 2D -> 3ch, unit scale
        MODE_ANG_S,  // 3ch -> angle
        MODE_ANG_M,  // 2D -> angle
        MODE_BAD
    } mode_t;

    typedef struct packed {
        logic               valid;
        mode_t              mode;
        logic [7:0]         a;
        logic [7:0]         b;
        logic [7:0]         s;
        logic signed [23:0] u;
        logic signed [23:0] w;
        logic signed [17:0] acc;
        logic [19:0]        v;
        logic [19:0]        res;
        logic [7:0]         kx;
        logic [7:0]         ky;
        logic [16:0]        ppx;
        logic [16:0]        ppy;
        logic               px_neg;
        logic               py_neg;
        logic [31:0]        qqx;
        logic [31:0]        qqy;
        logic               qx_neg;
        logic               qy_neg;
        logic [16:0]        r2;
    } cell_t;

    // arctangent of 2^-i, 65536 units per turn
    function automatic logic signed [17:0] arc_angle(input logic [3:0] idx);
        logic signed [17:0] r;
        unique case (idx)
            4'd0:  r = 18'sd8192;
            4'd1:  r = 18'sd4836;
            4'd2:  r = 18'sd2555;
            4'd3:  r = 18'sd1297;
            4'd4:  r = 18'sd651;
            4'd5:  r = 18'sd326;
            4'd6:  r = 18'sd163;
            4'd7:  r = 18'sd81;
            4'd8:  r = 18'sd41;
            4'd9:  r = 18'sd20;
            4'd10: r = 18'sd10;
            4'd11: r = 18'sd5;
            4'd12: r = 18'sd3;
            4'd13: r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/apec_front.sv @@
// Front end: format decode, swap, strength rescale, squares and products.
// Two register stages. Depends on apec_pkg.
`default_nettype none

module apec_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [7:0]    chan_a,
    input  wire logic [7:0]    chan_b,
    input  wire logic [7:0]    chan_c,
    input  wire logic [1:0]    in_fmt,
    input  wire logic [1:0]    out_fmt,
    output apec_pkg::cell_t    cell_out
);
    import apec_pkg::*;

    logic               swap;
    logic [7:0]         a_e, b_e, s2, s_e, m;
    logic [15:0]        s255;
    logic [1:0]         ifmt_e;
    mode_t              mode;
    logic signed [9:0]  dx, dy;

    logic               f1_valid_reg;
    mode_t              f1_mode_reg;
    logic [7:0]         f1_a_reg, f1_b_reg, f1_s_reg;
    logic signed [9:0]  f1_dx_reg, f1_dy_reg;
    logic signed [19:0] f1_dxsq_reg, f1_dysq_reg, f1_qx_reg, f1_qy_reg;

    logic signed [39:0] qqx, qqy;
    logic signed [23:0] u0, w0;
    cell_t              c_next;
    cell_t              cell_reg;

    always_comb begin
        swap   = (in_fmt == IFMT_SIGNED) && !chan_c[7];
        a_e    = swap ? chan_b : chan_a;
        b_e    = swap ? chan_a : chan_b;
        s2     = chan_c[7] ? {1'b0, chan_c[6:0]} : 8'd128 - chan_c;
        s255   = {s2, 8'b0} - {8'b0, s2};
        s_e    = (in_fmt == IFMT_SIGNED) ? s255[14:7] : chan_c;
        ifmt_e = (in_fmt == IFMT_SIGNED) ? IFMT_3CH : in_fmt;
        priority if (ifmt_e == IFMT_3CH && out_fmt == OFMT_3CH) mode = MODE_PASS;
        else if (ifmt_e == IFMT_3CH && out_fmt == OFMT_2D) mode = MODE_DIR_S;
        else if (ifmt_e == IFMT_3CH && out_fmt == OFMT_ANGLE) mode = MODE_ANG_S;
        else if (ifmt_e == IFMT_2D && out_fmt == OFMT_3CH) mode = MODE_DIR_M;
        else if (ifmt_e == IFMT_2D && out_fmt == OFMT_ANGLE) mode = MODE_ANG_M;
        else mode = MODE_BAD;
        dx = $signed({1'b0, a_e, 1'b0}) - 10'sd255;
        dy = $signed({1'b0, b_e, 1'b0}) - 10'sd255;
        m  = (mode == MODE_DIR_M) ? 8'd255 : s_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
        end
        if (en) begin
            f1_mode_reg <= mode;
            f1_a_reg    <= a_e;
            f1_b_reg    <= b_e;
            f1_s_reg    <= s_e;
            f1_dx_reg   <= dx;
            f1_dy_reg   <= dy;
            f1_dxsq_reg <= dx * dx;
            f1_dysq_reg <= dy * dy;
            f1_qx_reg   <= dx * $signed({2'b0, m});
            f1_qy_reg   <= dy * $signed({2'b0, m});
        end
    end

    always_comb begin
        qqx = f1_qx_reg * f1_qx_reg;
        qqy = f1_qy_reg * f1_qy_reg;
        u0  = {{14{f1_dy_reg[9]}}, f1_dy_reg} <<< DIR_SHIFT;
        w0  = {{14{f1_dx_reg[9]}}, f1_dx_reg} <<< DIR_SHIFT;
        c_next        = '0;
        c_next.valid  = f1_valid_reg;
        c_next.mode   = f1_mode_reg;
        c_next.a      = f1_a_reg;
        c_next.b      = f1_b_reg;
        c_next.s      = f1_s_reg;
        // start in the upper half plane
        if (u0 < 0) begin
            c_next.u   = -u0;
            c_next.w   = -w0;
            c_next.acc = 18'sd32768;
        end else begin
            c_next.u   = u0;
            c_next.w   = w0;
            c_next.acc = 18'sd0;
        end
        c_next.r2     = f1_dxsq_reg[16:0] + f1_dysq_reg[16:0];
        c_next.v      = {3'b0, c_next.r2};
        c_next.qqx    = qqx[31:0];
        c_next.qqy    = qqy[31:0];
        c_next.qx_neg = f1_qx_reg[19];
        c_next.qy_neg = f1_qy_reg[19];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= c_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

@@ rtl/apec_cell.sv @@
// A chain cell: vectoring rotation step (step_idx < 14), square-root step
// (< 10), half a bit step of each direction byte search. Uses apec_pkg.
`default_nettype none

module apec_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic [3:0]    step_idx,
    input  wire apec_pkg::cell_t cell_in,
    output apec_pkg::cell_t    cell_out
);
    import apec_pkg::*;

    logic signed [23:0] su, sw;
    logic [4:0]         sq_sh;
    logic [19:0]        sq_bit, sq_sum;
    logic [7:0]         bit8, tx, ty;
    logic signed [9:0]  px, py;
    logic signed [19:0] sqx, sqy;
    logic [33:0]        prodx, prody;
    logic               takex, takey;
    cell_t              c_next;
    cell_t              cell_reg;

    always_comb begin
        c_next = cell_in;
        su = cell_in.u >>> step_idx;
        sw = cell_in.w >>> step_idx;
        sq_sh  = 5'd18 - {step_idx, 1'b0};
        sq_bit = 20'd1 << sq_sh;
        sq_sum = cell_in.res + sq_bit;
        bit8 = 8'h80 >> step_idx[3:1];
        tx   = cell_in.kx | bit8;
        ty   = cell_in.ky | bit8;
        px   = $signed({1'b0, tx, 1'b0}) - 10'sd255;
        py   = $signed({1'b0, ty, 1'b0}) - 10'sd255;
        sqx  = px * px;
        sqy  = py * py;
        prodx = cell_in.ppx * cell_in.r2;
        prody = cell_in.ppy * cell_in.r2;
        takex = cell_in.px_neg ? (!cell_in.qx_neg || prodx >= {2'b0, cell_in.qqx})
                               : (!cell_in.qx_neg && prodx <= {2'b0, cell_in.qqx});
        takey = cell_in.py_neg ? (!cell_in.qy_neg || prody >= {2'b0, cell_in.qqy})
                               : (!cell_in.qy_neg && prody <= {2'b0, cell_in.qqy});

        if (step_idx < 4'(CORDIC_STEPS)) begin
            if (cell_in.w > 0) begin
                c_next.u   = cell_in.u + sw;
                c_next.w   = cell_in.w - su;
                c_next.acc = cell_in.acc + arc_angle(step_idx);
            end else begin
                c_next.u   = cell_in.u - sw;
                c_next.w   = cell_in.w + su;
                c_next.acc = cell_in.acc - arc_angle(step_idx);
            end
        end

        if (step_idx < 4'(SQRT_STEPS)) begin
            if (cell_in.v >= sq_sum) begin
                c_next.v   = cell_in.v - sq_sum;
                c_next.res = (cell_in.res >> 1) + sq_bit;
            end else begin
                c_next.res = cell_in.res >> 1;
            end
        end

        // even cell: square the candidate, odd cell: compare and keep
        if (!step_idx[0]) begin
            c_next.ppx    = sqx[16:0];
            c_next.ppy    = sqy[16:0];
            c_next.px_neg = px[9];
            c_next.py_neg = py[9];
        end else begin
            if (takex) c_next.kx = tx;
            if (takey) c_next.ky = ty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= c_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

@@ rtl/anisotropy_pixel_encoding_converter_unit.sv @@
// Anisotropy texel encoding converter, top level.
// Uses apec_pkg, apec_front and apec_cell.
//
// Usage:
//  - Config: APB registers input_format at 0x0 and output_format at 0x4,
//    both reset to 1 (3-channel in, 2D magnitude out). Write them only
//    while no texel is in flight. pready is tied high.
//  - Input: s_valid/s_ready request carrying chan_a, chan_b, chan_c.
//  - Output: m_valid/m_ready request carrying out_a, out_b, out_c and
//    the unsupported flag (all bytes zero when set).
//  - Throughput: one texel per cycle while the output is not stalled.
//  - Pipeline: 19 register stages (two front stages, a chain of 16 cells,
//    one output register). The chain length is set by the 14-step angle
//    rotation and the 8-bit direction search at two cells per bit.
//  - Stall: when the result is held (m_valid high, m_ready low) the
//    whole chain freezes and s_ready drops; nothing is lost.
//  - Reset: synchronous, active low; clears all valid bits and returns
//    both format registers to 1.
`default_nettype none

module anisotropy_pixel_encoding_converter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_chan_a,
    input  wire logic [7:0]  s_chan_b,
    input  wire logic [7:0]  s_chan_c,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_a,
    output logic [7:0]       m_out_b,
    output logic [7:0]       m_out_c,
    output logic             m_unsupported
);
    import apec_pkg::*;

    logic [1:0]  in_fmt_reg, out_fmt_reg;
    logic        en;
    cell_t       chain [0:NUM_CELLS];
    cell_t       last;
    logic [23:0] ang_full;
    logic [7:0]  ang, mclamp;
    logic [7:0]  oa, ob, oc;
    logic        bad;

    logic        m_valid_reg;
    logic [7:0]  out_a_reg, out_b_reg, out_c_reg;
    logic        bad_reg;

    // config registers
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_fmt_reg  <= IFMT_3CH;
            out_fmt_reg <= OFMT_2D;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_IN_FMT) in_fmt_reg  <= pwdata[1:0];
            else                        out_fmt_reg <= pwdata[1:0];
        end
    end
    assign prdata = (paddr[2] == REG_IN_FMT) ? {30'b0, in_fmt_reg} : {30'b0, out_fmt_reg};

    // whole pipe advances unless the output holds a result
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    apec_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .chan_a   (s_chan_a),
        .chan_b   (s_chan_b),
        .chan_c   (s_chan_c),
        .in_fmt   (in_fmt_reg),
        .out_fmt  (out_fmt_reg),
        .cell_out (chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        apec_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .step_idx (4'(i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    assign last = chain[NUM_CELLS];

    // angle byte = floor(turn16 * 255 / 65536)
    always_comb begin
        ang_full = {last.acc[15:0], 8'b0} - {8'b0, last.acc[15:0]};
        ang      = ang_full[23:16];
        mclamp   = (last.res > 20'd255) ? 8'd255 : last.res[7:0];
        oa = 8'd0;
        ob = 8'd0;
        oc = 8'd0;
        bad = 1'b0;
        unique case (last.mode)
            MODE_PASS:  begin oa = last.a;  ob = last.b;  oc = last.s;  end
            MODE_DIR_S: begin oa = last.kx; ob = last.ky; end
            MODE_DIR_M: begin oa = last.kx; ob = last.ky; oc = mclamp; end
            MODE_ANG_S: begin oa = ang;     ob = last.s;  end
            MODE_ANG_M: begin oa = ang;     ob = mclamp;  end
            default:    bad = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.valid;
        end
        if (en) begin
            out_a_reg <= oa;
            out_b_reg <= ob;
            out_c_reg <= oc;
            bad_reg   <= bad;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_a       = out_a_reg;
    assign m_out_b       = out_b_reg;
    assign m_out_c       = out_c_reg;
    assign m_unsupported = bad_reg;

endmodule

`default_nettype wire

@@ rtl/apec_checker.sv @@
// Port-level checks for the converter, bound to the top level.
// Depends on anisotropy_pixel_encoding_converter_unit.
`default_nettype none

module apec_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       pready,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_a,
    input wire logic [7:0] m_out_b,
    input wire logic [7:0] m_out_c,
    input wire logic       m_unsupported
);
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_a) && $stable(m_out_b)
            && $stable(m_out_c) && $stable(m_unsupported))
        else $error("held result changed");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unsupported |-> m_out_a == 8'd0 && m_out_b == 8'd0 && m_out_c == 8'd0)
        else $error("unsupported result not zero");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind anisotropy_pixel_encoding_converter_unit apec_checker u_apec_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_a       (m_out_a),
    .m_out_b       (m_out_b),
    .m_out_c       (m_out_c),
    .m_unsupported (m_unsupported)
);

`default_nettype wire
